[src/t2dpmi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2dpmi_pkg
// Shared types and constants for the Thumb-2 data-processing
// (modified immediate) execute block.
// ----------------------------------------------------------------------------
package t2dpmi_pkg;

    localparam int unsigned XLEN = 32;

    // Register number of the PC, also the marker for compare and move forms
    localparam logic [3:0] REG_PC = 4'hf;

    // Data-processing op codes, instruction bits 24:21
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_BIC = 4'd1,
        OP_ORR = 4'd2,
        OP_ORN = 4'd3,
        OP_EOR = 4'd4,
        OP_ADD = 4'd8,
        OP_ADC = 4'd10,
        OP_SBC = 4'd11,
        OP_SUB = 4'd13,
        OP_RSB = 4'd14
    } op_t;

    // Decoded instruction
    typedef struct packed {
        logic [3:0]      op;
        logic            set_flags;
        logic            rn_is_pc;
        logic [3:0]      rd;
        logic            cmp_form;
        logic [XLEN-1:0] imm;
        logic            exp_carry;
    } dec_t;

    // One executed result
    typedef struct packed {
        logic [XLEN-1:0] result;
        logic [3:0]      dest_reg;
        logic            write_result;
        logic            nzc_update;
        logic            v_update;
        logic            flag_n;
        logic            flag_z;
        logic            flag_c;
        logic            flag_v;
        logic            bad_opcode;
    } res_t;

endpackage

[src/t2dpmi_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2dpmi_decode
// Field decode, compare-form detection and modified-immediate expansion.
// ----------------------------------------------------------------------------
module t2dpmi_decode (
    input  logic [31:0]       instr_word,
    input  logic              carry_in,
    output t2dpmi_pkg::dec_t  dec
);
    import t2dpmi_pkg::*;

    logic [11:0]       imm12;
    logic [7:0]        imm_byte;
    logic [7:0]        rot_base;
    logic [4:0]        rot_amt;
    logic [2*XLEN-1:0] rot_wide;
    logic [XLEN-1:0]   rot_val;
    logic [XLEN-1:0]   pat_val;
    logic [3:0]        op;
    logic              s_bit;

    assign op       = instr_word[24:21];
    assign s_bit    = instr_word[20];
    assign imm12    = {instr_word[26], instr_word[14:12], instr_word[7:0]};
    assign imm_byte = imm12[7:0];

    // Rotated form: 1:imm7 rotated right by imm12[11:7]
    assign rot_base = {1'b1, imm12[6:0]};
    assign rot_amt  = imm12[11:7];
    assign rot_wide = {{(XLEN-8){1'b0}}, rot_base, {(XLEN-8){1'b0}}, rot_base} >> rot_amt;
    assign rot_val  = rot_wide[XLEN-1:0];

    // Replicated byte patterns
    always_comb
    begin
        case (imm12[9:8])
            2'd0:    pat_val = {24'd0, imm_byte};
            2'd1:    pat_val = {8'd0, imm_byte, 8'd0, imm_byte};
            2'd2:    pat_val = {imm_byte, 8'd0, imm_byte, 8'd0};
            default: pat_val = {imm_byte, imm_byte, imm_byte, imm_byte};
        endcase
    end

    always_comb
    begin
        dec.op        = op;
        dec.set_flags = s_bit;
        dec.rn_is_pc  = (instr_word[19:16] == REG_PC);
        dec.rd        = instr_word[11:8];
        // AND/EOR/ADD/SUB with Rd=PC and S=1 are TST/TEQ/CMN/CMP
        dec.cmp_form  = (instr_word[11:8] == REG_PC) && s_bit &&
                        (op inside {OP_AND, OP_EOR, OP_ADD, OP_SUB});
        if (imm12[11:10] == 2'b00)
        begin
            dec.imm       = pat_val;
            dec.exp_carry = carry_in;
        end
        else
        begin
            dec.imm       = rot_val;
            dec.exp_carry = rot_val[XLEN-1];
        end
    end

endmodule

[src/t2dpmi_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t2dpmi_alu
// Logical unit, 32-bit adder and flag generation for one decoded instruction.
// ----------------------------------------------------------------------------
module t2dpmi_alu (
    input  t2dpmi_pkg::dec_t  dec,
    input  logic [31:0]       rn_value,
    input  logic              carry_in,
    output t2dpmi_pkg::res_t  res
);
    import t2dpmi_pkg::*;

    logic [XLEN-1:0] add_a;
    logic [XLEN-1:0] add_b;
    logic            add_cin;
    logic [XLEN:0]   add_sum;
    logic [XLEN-1:0] add_res;
    logic            add_v;
    logic [XLEN-1:0] value;
    logic            arith;
    logic            bad;
    logic            upd;

    // Adder operand selection
    always_comb
    begin
        add_a   = rn_value;
        add_b   = dec.imm;
        add_cin = 1'b0;
        case (dec.op)
            OP_ADC:
            begin
                add_cin = carry_in;
            end
            OP_SBC:
            begin
                add_b   = ~dec.imm;
                add_cin = carry_in;
            end
            OP_SUB:
            begin
                add_b   = ~dec.imm;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_a   = ~rn_value;
                add_cin = 1'b1;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, add_cin};
    assign add_res = add_sum[XLEN-1:0];
    assign add_v   = ((add_a[XLEN-1] ^ add_res[XLEN-1]) & (add_b[XLEN-1] ^ add_res[XLEN-1]));

    // Operation select
    always_comb
    begin
        arith = 1'b0;
        bad   = 1'b0;
        case (dec.op)
            OP_AND: value = rn_value & dec.imm;
            OP_BIC: value = rn_value & ~dec.imm;
            OP_ORR: value = dec.rn_is_pc ? dec.imm : (rn_value | dec.imm);
            OP_ORN: value = dec.rn_is_pc ? ~dec.imm : (rn_value | ~dec.imm);
            OP_EOR: value = rn_value ^ dec.imm;
            OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB:
            begin
                value = add_res;
                arith = 1'b1;
            end
            default:
            begin
                value = '0;
                bad   = 1'b1;
            end
        endcase
    end

    assign upd = dec.cmp_form || dec.set_flags;

    // Result and flags; an undefined op code clears everything but the error
    always_comb
    begin
        res = '0;
        if (bad)
        begin
            res.bad_opcode = 1'b1;
        end
        else
        begin
            res.result       = value;
            res.write_result = !dec.cmp_form;
            res.dest_reg     = dec.cmp_form ? 4'd0 : dec.rd;
            if (upd)
            begin
                res.nzc_update = 1'b1;
                res.flag_n     = value[XLEN-1];
                res.flag_z     = (value == '0);
                if (arith)
                begin
                    res.v_update = 1'b1;
                    res.flag_c   = add_sum[XLEN];
                    res.flag_v   = add_v;
                end
                else
                begin
                    res.flag_c   = dec.exp_carry;
                end
            end
        end
    end

endmodule

[src/thumb2_dp_modified_immediate_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb2_dp_modified_immediate_exec
// Execute unit for Thumb-2 data-processing (modified immediate) instructions.
// ----------------------------------------------------------------------------
// Takes one instruction per clock with its Rn value and carry flag and returns
// the result, destination and new flags: the transfer lands in an input
// register, decode, immediate expansion and the 32-bit adder work on it
// combinationally, and the outcome is held in a result register until the
// consumer takes it. Throughput is one transfer per cycle; the input stalls
// only when both registers are full and the output is stalled.
module thumb2_dp_modified_immediate_exec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr_word,
    input  logic [31:0] rn_value,
    input  logic        carry_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result,
    output logic [3:0]  dest_reg,
    output logic        write_result,
    output logic        nzc_update,
    output logic        v_update,
    output logic        flag_n,
    output logic        flag_z,
    output logic        flag_c,
    output logic        flag_v,
    output logic        bad_opcode
);
    import t2dpmi_pkg::*;

    logic        s1_valid_reg;
    logic [31:0] instr_reg;
    logic [31:0] rn_reg;
    logic        cin_reg;
    logic        s2_valid_reg;
    res_t        res_reg;
    res_t        res_next;
    dec_t        dec;
    logic        s2_load;
    logic        s1_load;

    // Pipeline advance
    assign s2_load  = !s2_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            instr_reg <= instr_word;
            rn_reg    <= rn_value;
            cin_reg   <= carry_in;
        end
    end

    t2dpmi_decode u_decode (
        .instr_word (instr_reg),
        .carry_in   (cin_reg),
        .dec        (dec)
    );

    t2dpmi_alu u_alu (
        .dec      (dec),
        .rn_value (rn_reg),
        .carry_in (cin_reg),
        .res      (res_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign result       = res_reg.result;
    assign dest_reg     = res_reg.dest_reg;
    assign write_result = res_reg.write_result;
    assign nzc_update   = res_reg.nzc_update;
    assign v_update     = res_reg.v_update;
    assign flag_n       = res_reg.flag_n;
    assign flag_z       = res_reg.flag_z;
    assign flag_c       = res_reg.flag_c;
    assign flag_v       = res_reg.flag_v;
    assign bad_opcode   = res_reg.bad_opcode;

`ifndef ASSERT_OFF
    // A held item in the input register is not lost while the output stalls
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(instr_reg)))
        else $error("input register lost a stalled item");

    // Input stalls only with both stages occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // Undefined op code writes nothing
    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_opcode) |-> (!write_result && !nzc_update && !v_update))
        else $error("undefined op code produced a write");

    // V is only written together with N, Z and C
    a_v_with_nzc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && v_update) |-> nzc_update)
        else $error("V update without NZC update");

    // Compare forms and faults report register zero
    a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_result) |-> (dest_reg == 4'd0))
        else $error("nonzero destination without a register write");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Thumb-2 data-processing (modified immediate)
// execute block.
// ----------------------------------------------------------------------------
// A directed set covers every op code, the compare and move forms, undefined
// op codes, immediate expansion corners and adder overflow and carry. A long
// random run follows, mostly well-formed instruction encodings with biased
// register fields and operand values. An in-bench model predicts each result
// when the input transfer is accepted, and every output transfer is checked
// against the oldest prediction. Both sides idle at random, and at one point
// the consumer holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------

import t2dpmi_pkg::*;

// Predicts the block's outcome per accepted instruction and checks the outputs
class dp_imm_scoreboard;
    res_t        expected_q[$];
    int unsigned errors;

    function new();
        errors = 0;
    endfunction

    // Architectural immediate expansion with its carry out
    function logic [31:0] expand_imm(input logic [11:0] imm12, input logic cin,
                                     output logic cout);
        logic [7:0]  b;
        logic [31:0] v;
        logic [63:0] rot64;
        b = imm12[7:0];
        if (imm12[11:10] == 2'b00) begin
            // replicated byte patterns, selected by imm12[9:8]
            case (imm12[9:8])
                2'd0:    v = {24'd0, b};
                2'd1:    v = {8'd0, b, 8'd0, b};
                2'd2:    v = {b, 8'd0, b, 8'd0};
                default: v = {b, b, b, b};
            endcase
            cout = cin;
        end
        else begin
            // 1:imm7 rotated right by imm12[11:7]
            rot64 = {2{24'd0, 1'b1, imm12[6:0]}} >> imm12[11:7];
            v     = rot64[31:0];
            cout  = v[31];
        end
        return v;
    endfunction

    // Full execute of one instruction word
    function res_t execute(input logic [31:0] w, input logic [31:0] rn_val,
                           input logic cin);
        logic [3:0]  op;
        logic        s;
        logic [3:0]  rn;
        logic [3:0]  rd;
        logic [11:0] imm12;
        logic [31:0] imm;
        logic        icarry;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] res;
        logic        ci;
        logic [32:0] sum;
        logic        arith;
        logic        bad;
        logic        cmp_form;
        res_t        r;
        op    = w[24:21];
        s     = w[20];
        rn    = w[19:16];
        rd    = w[11:8];
        imm12 = {w[26], w[14:12], w[7:0]};
        imm   = expand_imm(imm12, cin, icarry);
        arith = 1'b0;
        bad   = 1'b0;
        res   = '0;
        x     = rn_val;
        y     = imm;
        ci    = 1'b0;
        case (op)
            OP_AND: res = rn_val & imm;
            OP_BIC: res = rn_val & ~imm;
            OP_ORR: res = (rn == REG_PC) ? imm : (rn_val | imm);
            OP_ORN: res = (rn == REG_PC) ? ~imm : (rn_val | ~imm);
            OP_EOR: res = rn_val ^ imm;
            OP_ADD: arith = 1'b1;
            OP_ADC:
            begin
                arith = 1'b1;
                ci    = cin;
            end
            OP_SBC:
            begin
                arith = 1'b1;
                y     = ~imm;
                ci    = cin;
            end
            OP_SUB:
            begin
                arith = 1'b1;
                y     = ~imm;
                ci    = 1'b1;
            end
            OP_RSB:
            begin
                arith = 1'b1;
                x     = ~rn_val;
                ci    = 1'b1;
            end
            default: bad = 1'b1;
        endcase
        sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
        if (arith)
            res = sum[31:0];

        r = '0;
        if (bad) begin
            r.bad_opcode = 1'b1;
            return r;
        end

        // TST, TEQ, CMN and CMP: flags only, nothing written
        cmp_form = (rd == REG_PC) && s &&
                   (op == OP_AND || op == OP_EOR || op == OP_ADD || op == OP_SUB);
        r.result       = res;
        r.write_result = !cmp_form;
        r.dest_reg     = cmp_form ? 4'd0 : rd;
        if (cmp_form || s) begin
            r.nzc_update = 1'b1;
            r.flag_n     = res[31];
            r.flag_z     = (res == 32'd0);
            if (arith) begin
                r.v_update = 1'b1;
                r.flag_c   = sum[32];
                r.flag_v   = (x[31] == y[31]) && (res[31] != x[31]);
            end
            else begin
                r.flag_c = icarry;
            end
        end
        return r;
    endfunction

    // Accepted input transfer: queue its expected outcome
    function void note_input(input logic [31:0] w, input logic [31:0] rn_val,
                             input logic cin);
        expected_q.push_back(execute(w, rn_val, cin));
    endfunction

    // Accepted output transfer: compare with the oldest expectation
    function void check_result(input res_t got);
        res_t exp_res;
        if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected output transfer: res=%h rd=%h bad=%b",
                         got.result, got.dest_reg, got.bad_opcode);
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.result       !== exp_res.result       ||
            got.dest_reg     !== exp_res.dest_reg     ||
            got.write_result !== exp_res.write_result ||
            got.nzc_update   !== exp_res.nzc_update   ||
            got.v_update     !== exp_res.v_update     ||
            got.flag_n       !== exp_res.flag_n       ||
            got.flag_z       !== exp_res.flag_z       ||
            got.flag_c       !== exp_res.flag_c       ||
            got.flag_v       !== exp_res.flag_v       ||
            got.bad_opcode   !== exp_res.bad_opcode) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: exp res=%h rd=%h wr=%b upd=%b%b nzcv=%b%b%b%b bad=%b",
                         exp_res.result, exp_res.dest_reg, exp_res.write_result,
                         exp_res.nzc_update, exp_res.v_update, exp_res.flag_n,
                         exp_res.flag_z, exp_res.flag_c, exp_res.flag_v,
                         exp_res.bad_opcode);
                $display("          got res=%h rd=%h wr=%b upd=%b%b nzcv=%b%b%b%b bad=%b",
                         got.result, got.dest_reg, got.write_result,
                         got.nzc_update, got.v_update, got.flag_n,
                         got.flag_z, got.flag_c, got.flag_v, got.bad_opcode);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_ITEMS  = 1725;
    localparam int unsigned IDLE_PCT      = 11;
    localparam int unsigned HOLD_CYCLES   = 64;
    localparam int unsigned HOLD_AT_ITEM  = 400;
    localparam int unsigned QUIET_FIRST   = 700;
    localparam int unsigned QUIET_LAST    = 1000;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // Fixed encoding bits 31:27 of the 32-bit data-processing immediate group
    localparam logic [4:0] T32_PREFIX = 5'b11110;

    localparam op_t DEFINED_OPS [10] = '{OP_AND, OP_BIC, OP_ORR, OP_ORN, OP_EOR,
                                         OP_ADD, OP_ADC, OP_SBC, OP_SUB, OP_RSB};
    localparam logic [3:0] UNDEFINED_OPS [6] = '{4'd5, 4'd6, 4'd7, 4'd9, 4'd12, 4'd15};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr_word;
    logic [31:0] rn_value;
    logic        carry_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] result;
    logic [3:0]  dest_reg;
    logic        write_result;
    logic        nzc_update;
    logic        v_update;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        bad_opcode;

    dp_imm_scoreboard sb;
    res_t             observed;
    int unsigned      cycle_cnt;
    bit               no_idle;
    bit               hold_req;
    bit               hold_done;

    thumb2_dp_modified_immediate_exec u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .instr_word   (instr_word),
        .rn_value     (rn_value),
        .carry_in     (carry_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result),
        .dest_reg     (dest_reg),
        .write_result (write_result),
        .nzc_update   (nzc_update),
        .v_update     (v_update),
        .flag_n       (flag_n),
        .flag_z       (flag_z),
        .flag_c       (flag_c),
        .flag_v       (flag_v),
        .bad_opcode   (bad_opcode)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Assemble a data-processing (modified immediate) instruction word
    function automatic logic [31:0] make_instr(input logic [3:0] op, input logic s,
                                               input logic [3:0] rn, input logic [3:0] rd,
                                               input logic [11:0] imm12);
        return {T32_PREFIX, imm12[11], 1'b0, op, s, rn, 1'b0, imm12[10:8], rd, imm12[7:0]};
    endfunction

    // Offer one input transfer; returns at the edge that accepts it
    task automatic send_item(input logic [31:0] w, input logic [31:0] rn_val,
                             input logic cin);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        instr_word <= w;
        rn_value   <= rn_val;
        carry_in   <= cin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(w, rn_val, cin);
    endtask

    // Mostly well-formed encodings with biased fields, some raw noise words
    task automatic next_random_item(output logic [31:0] w, output logic [31:0] rn_val,
                                    output logic cin);
        logic [3:0]  op;
        logic [3:0]  rn;
        logic [3:0]  rd;
        logic [11:0] imm12;
        logic [31:0] imm;
        logic        unused_c;
        if ($urandom_range(99) < 8) begin
            w = $urandom;
        end
        else begin
            if ($urandom_range(99) < 85)
                op = DEFINED_OPS[$urandom_range(9)];
            else
                op = UNDEFINED_OPS[$urandom_range(5)];
            rn    = ($urandom_range(3) == 0) ? REG_PC : 4'($urandom_range(15));
            rd    = ($urandom_range(3) == 0) ? REG_PC : 4'($urandom_range(15));
            imm12 = 12'($urandom_range(4095));
            if ($urandom_range(99) < 40)
                imm12[11:10] = 2'b00;
            w = make_instr(op, 1'($urandom_range(1)), rn, rd, imm12);
        end
        imm = sb.expand_imm({w[26], w[14:12], w[7:0]}, 1'b0, unused_c);
        // operand values aimed at zero results, overflow and carry corners
        case ($urandom_range(9))
            0:       rn_val = 32'h0000_0000;
            1:       rn_val = 32'hffff_ffff;
            2:       rn_val = 32'h8000_0000;
            3:       rn_val = 32'h7fff_ffff;
            4:       rn_val = imm;
            5:       rn_val = 32'd0 - imm;
            default: rn_val = $urandom;
        endcase
        cin = 1'($urandom_range(1));
    endtask

    // Output side: sample accepted transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            observed.result       = result;
            observed.dest_reg     = dest_reg;
            observed.write_result = write_result;
            observed.nzc_update   = nzc_update;
            observed.v_update     = v_update;
            observed.flag_n       = flag_n;
            observed.flag_z       = flag_z;
            observed.flag_c       = flag_c;
            observed.flag_v       = flag_v;
            observed.bad_opcode   = bad_opcode;
            sb.check_result(observed);
        end
    end

    // Output stall: random idling plus one long hold-off on request
    initial
    begin
        int unsigned hold_cnt;
        out_stall <= 1'b0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic [31:0] w;
        logic [31:0] rn_val;
        logic        cin;
        int unsigned n;
        int unsigned drain;
        sb         = new();
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        instr_word <= '0;
        rn_value   <= '0;
        carry_in   <= 1'b0;
        // Reset asserted at the start and released on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: each op, flag corners, compare and move forms, bad op codes
        send_item(make_instr(OP_AND, 1'b1, 4'd1, 4'd2, 12'h0ff), 32'hffff_ffff, 1'b1);
        send_item(make_instr(OP_BIC, 1'b0, 4'd0, 4'd3, 12'h1ab), 32'hffff_ffff, 1'b0);
        send_item(make_instr(OP_ORR, 1'b1, 4'd3, 4'd4, 12'h25a), 32'h0000_0000, 1'b1);
        send_item(make_instr(OP_ORN, 1'b1, 4'd4, 4'd5, 12'h3ff), 32'h0000_0000, 1'b0);
        send_item(make_instr(OP_EOR, 1'b1, 4'd5, 4'd6, 12'h400), 32'h1234_5678, 1'b0);
        send_item(make_instr(OP_ADD, 1'b1, 4'd6, 4'd7, 12'h001), 32'h7fff_ffff, 1'b0);
        send_item(make_instr(OP_ADC, 1'b1, 4'd7, 4'd8, 12'h000), 32'hffff_ffff, 1'b1);
        send_item(make_instr(OP_SBC, 1'b1, 4'd8, 4'd9, 12'hfff), 32'h0000_0000, 1'b0);
        send_item(make_instr(OP_SUB, 1'b1, 4'd9, 4'd10, 12'h001), 32'h8000_0000, 1'b1);
        send_item(make_instr(OP_RSB, 1'b1, 4'd10, 4'd11, 12'h000), 32'h0000_0000, 1'b0);
        send_item(make_instr(OP_AND, 1'b1, 4'd11, REG_PC, 12'h4ff), 32'hffff_ffff, 1'b0);
        send_item(make_instr(OP_EOR, 1'b1, 4'd12, REG_PC, 12'h3ff), 32'hffff_ffff, 1'b1);
        send_item(make_instr(OP_ADD, 1'b1, 4'd0, REG_PC, 12'h3ff), 32'h0000_0001, 1'b0);
        send_item(make_instr(OP_SUB, 1'b1, 4'd1, REG_PC, 12'h0ff), 32'h0000_00ff, 1'b0);
        send_item(make_instr(OP_ORR, 1'b0, REG_PC, 4'd2, 12'h7ff), 32'hdead_beef, 1'b1);
        send_item(make_instr(OP_ORN, 1'b1, REG_PC, 4'd3, 12'h800), 32'h0f0f_0f0f, 1'b0);
        send_item(make_instr(OP_AND, 1'b0, 4'd2, REG_PC, 12'h2c3), 32'hffff_ffff, 1'b1);
        send_item(make_instr(OP_ORR, 1'b1, 4'd13, 4'd13, 12'h100), 32'h8000_0000, 1'b1);
        send_item(make_instr(OP_ADD, 1'b0, REG_PC, REG_PC, 12'hf80), 32'hffff_ffff, 1'b1);
        for (n = 0; n < 6; n++)
            send_item(make_instr(UNDEFINED_OPS[n], 1'b1, 4'd5, 4'd6, 12'h0ff),
                      32'hffff_ffff, 1'b1);

        // Random run, with one consumer hold-off and a stretch with no idling
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM)
                hold_req = 1'b1;
            no_idle = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            next_random_item(w, rn_val, cin);
            send_item(w, rn_val, cin);
        end
        no_idle = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then a short grace period for stray transfers
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
